### rtl/core/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg: shared types, constants and functions of the radio packet framer
// Holds the frame constants, the configuration register indexes, the
// CRC-16 byte update and the tail pad limits used by the framer modules.
// ----------------------------------------------------------------------------
package rpf_pkg;

    // Tail pad counts of the two frame formats and the per-item byte limit.
    localparam int TAIL_PADS_FIFO = 12;
    localparam int TAIL_PADS_RAW  = 3;
    localparam int MAX_RESULTS    = 17;

    // Fixed byte values of the frame.
    localparam logic [7:0]  PAD_BYTE       = 8'hAA;
    localparam logic [7:0]  SYNC_BYTE      = 8'h2D;
    localparam logic [4:0]  NODE_MASK_BITS = 5'h1F;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  GROUP_RESET    = 8'd210;

    // Configuration register indexes.
    localparam logic [1:0] REG_FRAME_FORMAT = 2'd0;
    localparam logic [1:0] REG_GROUP_ID     = 2'd1;
    localparam logic [1:0] REG_NODE_ID      = 2'd2;

    // Frame format codes.
    localparam logic FMT_FIFO = 1'b0;
    localparam logic FMT_RAW  = 1'b1;

    // Header lengths, length byte included; the payload byte follows at this index.
    localparam logic [2:0] HDR_LEN_FIFO = 3'd2;
    localparam logic [2:0] HDR_LEN_RAW  = 3'd7;

    // One byte through the reflected CRC-16, eight bit steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Pads that fit after the CRC bytes when 'used' bytes precede them.
    function automatic int pad_limit(input int pads, input int used);
        int room;
        room = MAX_RESULTS - used - 2;
        if (room < 0) begin
            room = 0;
        end
        return (pads > room) ? room : pads;
    endfunction

    localparam int PADS_FIFO_HDR = pad_limit(TAIL_PADS_FIFO, 3);
    localparam int PADS_FIFO_CNT = pad_limit(TAIL_PADS_FIFO, 1);
    localparam int PADS_RAW_HDR  = pad_limit(TAIL_PADS_RAW, 8);
    localparam int PADS_RAW_CNT  = pad_limit(TAIL_PADS_RAW, 1);

    // CRC after the default group byte.
    localparam logic [15:0] SEED_RESET = crc_feed(CRC_INIT, GROUP_RESET);

    // Register values seen by the sequencer.
    typedef struct packed {
        logic        fmt;
        logic [7:0]  group;
        logic [7:0]  node;
        logic [15:0] seed;
    } cfg_t;

    // One accepted item as held for emission.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] len;
        logic       hdr;
        logic       fmt;
        logic       close;
        logic [2:0] hlen;
        logic [4:0] last;
    } item_t;

endpackage

### rtl/core/radio_packet_framer_crc16.sv
// ----------------------------------------------------------------------------
// radio_packet_framer_crc16: radio packet framer with CRC-16
// Frames payload bytes into a transmit byte stream with header, CRC-16
// (reflected 0xA001, seeded by the group byte) and tail pad bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Moves
//  s_axis    in         one payload item: payload byte and packet length
//  m_axis    out        one transmit byte, tlast on the final packet byte
//  cfg       in         register write: index, data
//
//  One byte leaves per cycle from the output register while the output is not
//  stalled; an item holds the sequencer for its bytes: 1 inside a packet,
//  3 or 8 on the first item, plus 2 CRC bytes and the pads on the last item.
//  A mid-packet item is accepted every cycle while the output is not stalled.
//  Items with zero length are taken and dropped. Reset is synchronous,
//  active low; output stalls hold the current byte and back-pressure the input.
// ----------------------------------------------------------------------------
module radio_packet_framer_crc16 import rpf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] payload_byte, [15:8] payload_length
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic        m_tlast,   // end_of_packet
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t cfg;

    // Configuration registers.
    rpf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Byte sequencer.
    rpf_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_data  (s_tdata[7:0]),
        .in_len   (s_tdata[15:8]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_byte (m_tdata),
        .out_last (m_tlast)
    );

endmodule

### rtl/core/rpf_cfg.sv
// ----------------------------------------------------------------------------
// rpf_cfg: configuration registers of the radio packet framer
// Holds frame format, group and node bytes, and the CRC seed that follows
// from the group byte, updated at each group write.
// ----------------------------------------------------------------------------
module rpf_cfg import rpf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    logic        fmt_reg;
    logic [7:0]  group_reg;
    logic [7:0]  node_reg;
    logic [15:0] seed_reg;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // Register writes; writes to an unused index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= FMT_FIFO;
            group_reg <= GROUP_RESET;
            node_reg  <= 8'h00;
            seed_reg  <= SEED_RESET;
        end else if (wr) begin
            case (cfg_index)
                REG_FRAME_FORMAT: fmt_reg <= cfg_data[0];
                REG_GROUP_ID: begin
                    group_reg <= cfg_data;
                    seed_reg  <= crc_feed(CRC_INIT, cfg_data);
                end
                REG_NODE_ID: node_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.fmt   = fmt_reg;
    assign cfg.group = group_reg;
    assign cfg.node  = node_reg;
    assign cfg.seed  = seed_reg;

endmodule

### rtl/core/rpf_seq.sv
// ----------------------------------------------------------------------------
// rpf_seq: item register, packet tracking and byte sequencer
// Takes payload items, tracks the open packet, and emits header, payload,
// CRC and pad bytes one per cycle into the output register unless it stalls.
// ----------------------------------------------------------------------------
module rpf_seq import rpf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] in_data,
    input  logic [7:0] in_len,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    item_t       item_reg;
    item_t       item_next;
    logic        busy_reg;
    logic [4:0]  k_reg;
    logic [15:0] crc_reg;
    logic        open_reg;
    logic [7:0]  taken_reg;
    logic        mvalid_reg;
    logic [7:0]  mbyte_reg;
    logic        mlast_reg;

    logic        advance;
    logic        emit;
    logic        at_last;
    logic        accept;
    logic        load;
    logic [7:0]  taken_inc;
    logic        close_now;
    logic [4:0]  pads;
    logic [4:0]  off;
    logic        in_hdr;
    logic [7:0]  byte_sel;
    logic        feed_en;
    logic [15:0] crc_in;
    logic [15:0] crc_step;

    // Handshake: the output register frees when empty or taken.
    assign advance  = !mvalid_reg || m_tready;
    assign at_last  = (k_reg == item_reg.last);
    assign emit     = busy_reg && advance;
    assign s_tready = !busy_reg || (emit && at_last);
    assign accept   = s_tvalid && s_tready;
    assign load     = accept && (in_len != 8'h00);

    // Packet tracking for the incoming item.
    assign taken_inc = (open_reg ? taken_reg : 8'h00) + 8'h01;
    assign close_now = (taken_inc >= in_len);

    always_comb begin
        if (cfg.fmt == FMT_FIFO) begin
            pads = open_reg ? 5'(PADS_FIFO_CNT) : 5'(PADS_FIFO_HDR);
        end else begin
            pads = open_reg ? 5'(PADS_RAW_CNT) : 5'(PADS_RAW_HDR);
        end
        item_next.data  = in_data;
        item_next.len   = in_len;
        item_next.hdr   = !open_reg;
        item_next.fmt   = cfg.fmt;
        item_next.close = close_now;
        if (open_reg) begin
            item_next.hlen = 3'd0;
        end else begin
            item_next.hlen = (cfg.fmt == FMT_FIFO) ? HDR_LEN_FIFO : HDR_LEN_RAW;
        end
        item_next.last = {2'b00, item_next.hlen} + (close_now ? (pads + 5'd2) : 5'd0);
    end

    // Byte at the current step of the item, and whether it enters the CRC.
    always_comb begin
        off      = k_reg - {2'b00, item_reg.hlen};
        in_hdr   = item_reg.hdr && (k_reg < {2'b00, item_reg.hlen});
        byte_sel = PAD_BYTE;
        feed_en  = 1'b0;
        if (in_hdr) begin
            if (item_reg.fmt == FMT_FIFO) begin
                feed_en  = 1'b1;
                byte_sel = (k_reg == 5'd0) ? {3'b000, cfg.node[4:0] & NODE_MASK_BITS}
                                           : item_reg.len;
            end else begin
                case (k_reg[2:0])
                    3'd3: byte_sel = SYNC_BYTE;
                    3'd4: byte_sel = cfg.group;
                    3'd5: begin
                        byte_sel = cfg.node;
                        feed_en  = 1'b1;
                    end
                    3'd6: begin
                        byte_sel = item_reg.len;
                        feed_en  = 1'b1;
                    end
                    default: byte_sel = PAD_BYTE;
                endcase
            end
        end else if (off == 5'd0) begin
            byte_sel = item_reg.data;
            feed_en  = 1'b1;
        end else if (off == 5'd1) begin
            byte_sel = crc_reg[7:0];
        end else if (off == 5'd2) begin
            byte_sel = crc_reg[15:8];
        end else begin
            byte_sel = PAD_BYTE;
        end
    end

    // The first header byte starts from the group-seeded CRC.
    assign crc_in   = (item_reg.hdr && (k_reg == 5'd0)) ? cfg.seed : crc_reg;
    assign crc_step = feed_en ? crc_feed(crc_in, byte_sel) : crc_in;

    // Control registers; a new item restarts the step count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            k_reg      <= 5'd0;
            crc_reg    <= CRC_INIT;
            open_reg   <= 1'b0;
            taken_reg  <= 8'h00;
            mvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                crc_reg <= crc_step;
            end
            if (load) begin
                busy_reg  <= 1'b1;
                k_reg     <= 5'd0;
                open_reg  <= !close_now;
                taken_reg <= close_now ? 8'h00 : taken_inc;
            end else if (emit) begin
                k_reg <= k_reg + 5'd1;
                if (at_last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (emit) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
        if (emit) begin
            mbyte_reg <= byte_sel;
            mlast_reg <= at_last && item_reg.close;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign out_byte = mbyte_reg;
    assign out_last = mlast_reg;

endmodule

### dv/radio_packet_framer_crc16_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radio_packet_framer_crc16_test: self-checking bench of the packet framer
// Feeds payload items through the input stream and predicts every transmit
// byte: header, CRC-16 over group, node, length and payload, and tail pads.
// A directed opening covers the corner cases. Random packets then run under
// four input and output idling patterns, with register changes between and
// inside packets.
// ----------------------------------------------------------------------------
module radio_packet_framer_crc16_test;
    import rpf_pkg::*;

    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 40;

    // One transmit byte as it should leave the block.
    typedef struct packed {
        logic [7:0] tx;
        logic       eop;
    } tx_expect_t;

    // Predicts the transmit stream and checks the bytes that leave the block.
    class framer_scoreboard;
        logic        fmt_reg;
        logic [7:0]  group_reg;
        logic [7:0]  node_reg;
        logic [15:0] crc_acc;
        logic [7:0]  taken_cnt;
        bit          pkt_open;
        int          burst_n;
        tx_expect_t  expected_bytes[$];
        int          mismatches;

        function new();
            fmt_reg    = FMT_FIFO;
            group_reg  = GROUP_RESET;
            node_reg   = 8'h00;
            crc_acc    = CRC_INIT;
            taken_cnt  = 8'd0;
            pkt_open   = 1'b0;
            burst_n    = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                REG_FRAME_FORMAT: fmt_reg = value[0];
                REG_GROUP_ID:     group_reg = value;
                REG_NODE_ID:      node_reg = value;
                // Writes past the register list change nothing.
                default: ;
            endcase
        endfunction

        // Reflected CRC-16, one bit per step, least significant bit first.
        function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        // Bytes past the per-item limit are dropped.
        function void push_byte(logic [7:0] b, logic eop);
            if (burst_n < MAX_RESULTS) begin
                expected_bytes.push_back(tx_expect_t'{b, eop});
                burst_n++;
            end
        endfunction

        function void push_covered(logic [7:0] b);
            push_byte(b, 1'b0);
            crc_acc = crc16_step(crc_acc, b);
        endfunction

        // Works out the bytes that one accepted item causes.
        function void note_item(logic [7:0] data, logic [7:0] len);
            int          pads;
            int          room;
            logic [15:0] crc;
            if (len == 8'd0) return;
            burst_n = 0;
            // The first item of a packet brings the header with it.
            if (!pkt_open) begin
                crc_acc   = crc16_step(CRC_INIT, group_reg);
                taken_cnt = 8'd0;
                pkt_open  = 1'b1;
                if (fmt_reg == FMT_FIFO) begin
                    push_covered(node_reg & {3'b000, NODE_MASK_BITS});
                end else begin
                    repeat (3) push_byte(PAD_BYTE, 1'b0);
                    push_byte(SYNC_BYTE, 1'b0);
                    push_byte(group_reg, 1'b0);
                    push_covered(node_reg);
                end
                push_covered(len);
            end
            push_covered(data);
            taken_cnt++;
            // The tail follows the format that holds at the closing item.
            if (taken_cnt >= len) begin
                crc  = crc_acc;
                pads = (fmt_reg == FMT_FIFO) ? TAIL_PADS_FIFO : TAIL_PADS_RAW;
                room = MAX_RESULTS - burst_n - 2;
                if (pads > room) pads = room;
                if (pads < 0) pads = 0;
                push_byte(crc[7:0], 1'b0);
                push_byte(crc[15:8], pads == 0);
                for (int k = 0; k < pads; k++) push_byte(PAD_BYTE, k == pads - 1);
                crc_acc   = CRC_INIT;
                taken_cnt = 8'd0;
                pkt_open  = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [7:0] b, logic eop);
            tx_expect_t want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h with none expected", b));
                return;
            end
            want = expected_bytes.pop_front();
            if (b !== want.tx)
                report_mismatch($sformatf("tx_byte %02h, expected %02h", b, want.tx));
            if (eop !== want.eop)
                report_mismatch($sformatf("end_of_packet %0b, expected %0b", eop, want.eop));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_FRAME_FORMAT;
    logic [7:0]  cfg_data = 8'h00;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    framer_scoreboard sb = new();

    radio_packet_framer_crc16 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Output back-pressure at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every transmit byte taken is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // Ends the run when no channel has moved anything for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, with optional idle cycles ahead of it, until taken.
    task automatic send_item(input logic [7:0] data, input logic [7:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(data, len);
        if (len != 8'd0) items_sent++;
    endtask

    // Lets the block run dry so that registers may be written.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Register writes lean toward the extremes of the data byte.
    task automatic write_random_reg();
        int pick;
        logic [7:0] value;
        pick  = $urandom_range(3);
        value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
        write_cfg(2'($urandom_range(3)), value);
    endtask

    // A packet of random bytes, now and then broken by noise: ignored items,
    // a length that differs from the rest, or a register write mid-packet.
    task automatic send_random_packet(input int len);
        int roll;
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                send_item(8'($urandom_range(255)), 8'd0);
            end else if (roll < 6) begin
                wait_quiet();
                write_random_reg();
            end
            if (roll >= 6 && roll < 9) begin
                send_item(8'($urandom_range(255)), 8'($urandom_range(1, 255)));
            end else begin
                send_item(8'($urandom_range(255)), 8'(len));
            end
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
        int goal;
        int pick;
        int len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 30) begin
                wait_quiet();
                write_random_reg();
            end
            pick = $urandom_range(99);
            len  = (pick < 70) ? $urandom_range(1, 6) :
                   (pick < 95) ? $urandom_range(7, 24) : $urandom_range(25, 60);
            send_random_packet(len);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults after reset, a single-byte packet.
        send_item(8'h00, 8'd1);
        // A zero-length item is dropped.
        send_item(8'hFF, 8'd0);

        // Node byte with its upper bits set, masked in the FIFO format.
        wait_quiet();
        write_cfg(REG_GROUP_ID, 8'hFF);
        write_cfg(REG_NODE_ID, 8'hFF);
        send_item(8'hFF, 8'd2);
        send_item(8'h80, 8'd2);

        // Raw format with preamble and sync.
        wait_quiet();
        write_cfg(REG_FRAME_FORMAT, {7'd0, FMT_RAW});
        write_cfg(REG_GROUP_ID, 8'h00);
        write_cfg(REG_NODE_ID, 8'h00);
        send_item(8'h7F, 8'd1);
        wait_quiet();
        write_cfg(REG_NODE_ID, 8'hFF);
        send_item(8'h01, 8'd3);
        send_item(8'hFE, 8'd3);
        send_item(8'hAA, 8'd3);

        // The longest length, then a shorter one that closes the packet.
        send_item(8'h12, 8'd255);
        send_item(8'h34, 8'd1);

        // Registers change inside a packet: the header keeps the old values,
        // the tail takes the new format, and a write past the list is dropped.
        send_item(8'h5A, 8'd2);
        wait_quiet();
        write_cfg(REG_FRAME_FORMAT, {7'd0, FMT_FIFO});
        write_cfg(REG_GROUP_ID, 8'h81);
        write_cfg(REG_NODE_ID, 8'h3C);
        write_cfg(2'd3, 8'hFF);
        send_item(8'hC3, 8'd2);

        // Zero-length item inside an open packet.
        send_item(8'h11, 8'd3);
        send_item(8'h22, 8'd0);
        send_item(8'h33, 8'd3);
        send_item(8'h44, 8'd3);

        // Random packets under each idling pattern.
        run_random_phase(0, 0, 40);
        run_random_phase(79, 0, 40);
        run_random_phase(0, 79, 40);
        run_random_phase(26, 26, 40);

        wait_quiet();
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
